[rtl/avm_pkg.sv]
`timescale 1ns / 1ps

package avm_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int VALUE_W   = 12;
	localparam int PERIOD_W  = 10;
	localparam int SEG_W     = 8;
	localparam int DIGITS    = 4;
	localparam int CFG_IDX_W = 1;

	localparam int AVG_LOG2  = 3;
	localparam int AVG_DEPTH = 1 << AVG_LOG2;
	localparam int SUM_W     = VALUE_W + AVG_LOG2;

	// floor(s * 100 / 33) == (s * 12710100) >> 22 for every 10-bit s.
	localparam int          SCALE_SHIFT = 22;
	localparam logic [23:0] SCALE_MULT  = 24'd12710100;
	localparam int          SCALE_W     = SAMPLE_W + 24;

	// floor(x / 10) == (x * 3277) >> 15 for every 12-bit x.
	localparam int          DIV10_SHIFT = 15;
	localparam logic [11:0] DIV10_MULT  = 12'd3277;
	localparam int          QUOT_W      = 9;

	localparam logic [SEG_W-1:0]      DP_MASK     = 8'h80;
	localparam logic [PERIOD_W-1:0]   HALF_RESET  = 10'd500;
	localparam logic [PERIOD_W-1:0]   FULL_RESET  = 10'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_PERIOD = 1'b0,
		REG_FULL_PERIOD = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} opcode_t;

	typedef struct packed {
		logic                opcode;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [SEG_W-1:0]   segments;
		logic [DIGITS-1:0]  digit_enables;
		logic               blink;
		logic [VALUE_W-1:0] shown_value;
	} out_item_t;

	typedef struct packed {
		logic [QUOT_W-1:0] quot;
		logic [3:0]        digit;
	} divmod_t;

	function automatic logic [VALUE_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] s);
		logic [SCALE_W-1:0] p;
		p = SCALE_W'(s) * SCALE_W'(SCALE_MULT);
		return p[SCALE_SHIFT +: VALUE_W];
	endfunction

	function automatic divmod_t divmod10(input logic [VALUE_W-1:0] x);
		logic [2*VALUE_W-1:0] p;
		logic [QUOT_W-1:0]    q;
		logic [VALUE_W-1:0]   t;
		divmod_t              r;
		p = (2*VALUE_W)'(x) * (2*VALUE_W)'(DIV10_MULT);
		q = p[DIV10_SHIFT +: QUOT_W];
		t = x - (VALUE_W'(q) * VALUE_W'(10));
		r.quot  = q;
		r.digit = t[3:0];
		return r;
	endfunction

	function automatic logic [SEG_W-1:0] seg7(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7C;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h67;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

[rtl/averaging_voltmeter_display.sv]
`timescale 1ns / 1ps
// Items pass through the input register to the result registers. Throughput: one item per
// cycle; input stalls only while the input register is full and a result is stalled. All
// per-item work (scaling multiply, running sum, tick compare, digit step) is done between
// them. Reset (arst_n low, asynchronous) clears the average store, the counters, the display
// state and both pipeline valids, and sets the periods to 500 and 1000.
module averaging_voltmeter_display (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  avm_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output avm_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [avm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [avm_pkg::PERIOD_W-1:0]  cfg_data
);
	import avm_pkg::*;

	logic                valid_s1;
	in_item_t            item_s1;
	logic                out_valid_q;
	logic                advance;
	logic                tick_step;
	logic                sample_load;

	logic [PERIOD_W-1:0] half_q;
	logic [PERIOD_W-1:0] full_q;
	logic [PERIOD_W-1:0] tick_q;
	logic [PERIOD_W-1:0] tick_inc;
	logic                wrap;
	logic                update;
	logic [VALUE_W-1:0]  latched_q;
	logic                blink_q;
	logic [VALUE_W-1:0]  average;
	logic [SEG_W-1:0]    segments;
	logic [DIGITS-1:0]   digit_enables;

	assign advance     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall    = valid_s1 && !advance;
	assign tick_step   = advance && (item_s1.opcode == OP_TICK);
	assign sample_load = advance && (item_s1.opcode == OP_SAMPLE);
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (advance) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
			full_q <= FULL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_PERIOD: half_q <= cfg_data;
				REG_FULL_PERIOD: full_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		tick_inc = tick_q + PERIOD_W'(1);
		wrap     = (tick_inc >= full_q);
		update   = wrap || (tick_inc == half_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			latched_q <= '0;
			blink_q   <= 1'b0;
		end else if (tick_step) begin
			tick_q <= wrap ? '0 : tick_inc;
			if (update) begin
				latched_q <= average;
				blink_q   <= ~blink_q;
			end
		end
	end

	avm_average u_average (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (sample_load),
		.sample  (item_s1.sample),
		.average (average)
	);

	// The multiplexer steps on the latched value from before this tick's update.
	avm_digit_mux u_digit_mux (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (tick_step),
		.latched       (latched_q),
		.segments      (segments),
		.digit_enables (digit_enables)
	);

	assign out_valid              = out_valid_q;
	assign out_data.segments      = segments;
	assign out_data.digit_enables = digit_enables;
	assign out_data.blink         = blink_q;
	assign out_data.shown_value   = latched_q;

	a_no_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_step |=> ($stable(blink_q) && $stable(latched_q) && $stable(tick_q)))
		else $error("Display state changed without a tick transfer.");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_data)))
		else $error("Result changed while the result was stalled.");
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("Input stalled while the pipeline could move.");

endmodule

[rtl/avm_average.sv]
`timescale 1ns / 1ps

module avm_average (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [avm_pkg::SAMPLE_W-1:0] sample,
	output logic [avm_pkg::VALUE_W-1:0]  average
);
	import avm_pkg::*;

	logic [VALUE_W-1:0]  history_q [AVG_DEPTH];
	logic [SUM_W-1:0]    sum_q;
	logic [AVG_LOG2-1:0] slot_q;
	logic [VALUE_W-1:0]  scaled;
	logic [SUM_W-1:0]    sum_next;

	always_comb begin
		scaled   = scale_sample(sample);
		sum_next = sum_q - SUM_W'(history_q[slot_q]) + SUM_W'(scaled);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_DEPTH; i++) history_q[i] <= '0;
			sum_q  <= '0;
			slot_q <= '0;
		end else if (load) begin
			history_q[slot_q] <= scaled;
			sum_q             <= sum_next;
			slot_q            <= slot_q + AVG_LOG2'(1);
		end
	end

	assign average = sum_q[AVG_LOG2 +: VALUE_W];

endmodule

[rtl/avm_digit_mux.sv]
`timescale 1ns / 1ps

module avm_digit_mux (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [avm_pkg::VALUE_W-1:0] latched,
	output logic [avm_pkg::SEG_W-1:0]   segments,
	output logic [avm_pkg::DIGITS-1:0]  digit_enables
);
	import avm_pkg::*;

	typedef enum logic [2:0] {
		PH_UNITS,
		PH_TENS,
		PH_HUNDREDS,
		PH_THOUSANDS,
		PH_RELOAD,
		PH_IDLE
	} phase_t;

	phase_t             phase_q;
	logic [SEG_W-1:0]   seg_q;
	logic [DIGITS-1:0]  en_q;
	logic [VALUE_W-1:0] work_q;
	logic [QUOT_W-1:0]  quot_q;
	divmod_t            dm;
	logic [DIGITS-1:0]  en_lo;
	logic [DIGITS-1:0]  en_hi;

	always_comb begin
		dm    = divmod10((phase_q == PH_UNITS) ? work_q : VALUE_W'(quot_q));
		en_hi = DIGITS'(1) << phase_q[1:0];
		en_lo = DIGITS'(1) << (phase_q[1:0] - 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UNITS;
			seg_q   <= '0;
			en_q    <= '0;
			work_q  <= '0;
			quot_q  <= '0;
		end else if (step) begin
			case (phase_q)
				PH_UNITS: begin
					seg_q   <= seg7(dm.digit);
					en_q    <= en_q | DIGITS'(1);
					quot_q  <= dm.quot;
					phase_q <= PH_TENS;
				end
				PH_TENS, PH_HUNDREDS, PH_THOUSANDS: begin
					seg_q   <= seg7(dm.digit) | ((phase_q == PH_HUNDREDS) ? DP_MASK : '0);
					en_q    <= (en_q & ~en_lo) | en_hi;
					work_q  <= VALUE_W'(quot_q);
					quot_q  <= dm.quot;
					phase_q <= phase_t'(phase_q + 3'd1);
				end
				PH_RELOAD: begin
					seg_q   <= '0;
					en_q    <= en_q & 4'b0111;
					work_q  <= latched;
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_UNITS;
				end
			endcase
		end
	end

	assign segments      = seg_q;
	assign digit_enables = en_q;

	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(en_q))
		else $error("More than one digit driven at once.");
	a_idle_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (en_q == '0 && seg_q == '0))
		else $error("Display not blank in the idle phase.");
	a_hundreds_dp: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_HUNDREDS) |=> (seg_q[SEG_W-1] && en_q[2]))
		else $error("Hundreds digit shown without its decimal point.");

endmodule
